// File: rtl/core/ffdl_pkg.sv
// shared types, constants and register map for the fractional feedback delay line
// no dependencies; compiled first

package ffdl_pkg;

   // payload widths
   localparam int SAMPLE_W   = 16;
   localparam int DELAY_W    = 20;
   localparam int LOOP_LEN_W = 13;

   // default geometry
   localparam int DEPTH_DEFAULT     = 4096;
   localparam int FRAC_BITS_DEFAULT = 8;

   // sample range
   localparam int SAMPLE_MAX = 32767;
   localparam int SAMPLE_MIN = -32768;

   // feedback clamp, 0.99 in q1.15
   localparam logic signed [SAMPLE_W-1:0] PROTECT_POS = 16'sd32440;
   localparam logic signed [SAMPLE_W-1:0] PROTECT_NEG = -16'sd32440;

   // csr port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_MUTE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTERPOLATE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PROTECT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LOOP_LENGTH = 3'd4;

   localparam logic [LOOP_LEN_W-1:0] LOOP_LEN_RESET = 13'd2205;

   typedef struct packed {
      logic                  mute;
      logic                  interpolate;
      logic                  hold;
      logic                  gain_limit;
      logic [LOOP_LEN_W-1:0] loop_length;
   } ffdl_cfg_type;

   // controller to datapath
   typedef struct packed {
      logic clear;   // write zero at sweep address
      logic accept;  // latch transaction fields
      logic clamp;   // clamp delay, split integer and fraction
      logic addr;    // tap addresses
      logic rd1;     // read first tap
      logic rd2;     // read second tap, first tap data returns
      logic mix;     // blend taps
      logic fb;      // feedback product
      logic done;    // store write, position advance, result load
   } ffdl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } ffdl_sts_type;

endpackage

// File: rtl/core/ffdl_req_if.sv
// input channel: sample, delay and feedback gain with valid/ready
// depends on ffdl_pkg

interface ffdl_req_if
   import ffdl_pkg::*;
   ;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] in_sample;
   logic        [DELAY_W-1:0]  delay_amount;
   logic signed [SAMPLE_W-1:0] gain;

   modport source(output valid, output in_sample, output delay_amount, output gain,
                  input ready);
   modport sink(input valid, input in_sample, input delay_amount, input gain,
                output ready);
endinterface

// File: rtl/core/ffdl_rsp_if.sv
// result channel: delayed tap sample with valid/ready
// depends on ffdl_pkg

interface ffdl_rsp_if
   import ffdl_pkg::*;
   ;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] out_sample;

   modport source(output valid, output out_sample, input ready);
   modport sink(input valid, input out_sample, output ready);
endinterface

// File: rtl/core/ffdl_csr.sv
// apb-style configuration registers of the delay line
// depends on ffdl_pkg

module ffdl_csr
   import ffdl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output ffdl_cfg_type          cfg
);

   ffdl_cfg_type           cfg_ff;
   logic [CSR_IDX_W-1:0]   idx;
   logic                   wr_en;

   assign idx        = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mute        <= 1'b0;
         cfg_ff.interpolate <= 1'b0;
         cfg_ff.hold        <= 1'b0;
         cfg_ff.gain_limit  <= 1'b0;
         cfg_ff.loop_length <= LOOP_LEN_RESET;
      end else if (wr_en) begin
         unique case (idx)
            REG_MUTE:        cfg_ff.mute        <= csr_pwdata[0];
            REG_INTERPOLATE: cfg_ff.interpolate <= csr_pwdata[0];
            REG_HOLD:        cfg_ff.hold        <= csr_pwdata[0];
            REG_PROTECT:     cfg_ff.gain_limit  <= csr_pwdata[0];
            REG_LOOP_LENGTH: cfg_ff.loop_length <= csr_pwdata[LOOP_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_MUTE:        csr_prdata = CSR_DATA_W'(cfg_ff.mute);
         REG_INTERPOLATE: csr_prdata = CSR_DATA_W'(cfg_ff.interpolate);
         REG_HOLD:        csr_prdata = CSR_DATA_W'(cfg_ff.hold);
         REG_PROTECT:     csr_prdata = CSR_DATA_W'(cfg_ff.gain_limit);
         REG_LOOP_LENGTH: csr_prdata = CSR_DATA_W'(cfg_ff.loop_length);
         default:         csr_prdata = '0;
      endcase
   end

endmodule

// File: rtl/core/ffdl_ctrl.sv
// sequencer for the delay line: clearing sweep, then one transaction at a time
// depends on ffdl_pkg

module ffdl_ctrl
   import ffdl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ffdl_cfg_type cfg,
   input  logic         req_valid,
   output logic         req_ready,
   input  ffdl_sts_type sts,
   output ffdl_cmd_type cmd
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_CLAMP = 4'd2;
   localparam logic [3:0] S_ADDR  = 4'd3;
   localparam logic [3:0] S_READ1 = 4'd4;
   localparam logic [3:0] S_READ2 = 4'd5;
   localparam logic [3:0] S_MIX   = 4'd6;
   localparam logic [3:0] S_FB    = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = cfg.mute ? S_DONE : S_CLAMP;
            end
         end
         S_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = S_ADDR;
         end
         S_ADDR: begin
            cmd.addr = 1'b1;
            state_in = S_READ1;
         end
         S_READ1: begin
            cmd.rd1  = 1'b1;
            state_in = S_READ2;
         end
         S_READ2: begin
            cmd.rd2  = 1'b1;
            state_in = cfg.interpolate ? S_MIX : S_FB;
         end
         S_MIX: begin
            cmd.mix  = 1'b1;
            state_in = S_FB;
         end
         S_FB: begin
            cmd.fb   = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.done = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/ffdl_datapath.sv
// delay store, tap addressing, interpolation, feedback and result register
// depends on ffdl_pkg; driven by ffdl_ctrl

module ffdl_datapath
   import ffdl_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ffdl_cfg_type               cfg,
   input  ffdl_cmd_type               cmd,
   output ffdl_sts_type               sts,
   input  logic signed [SAMPLE_W-1:0] req_in_sample,
   input  logic        [DELAY_W-1:0]  req_delay_amount,
   input  logic signed [SAMPLE_W-1:0] req_gain,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_out_sample
);

   localparam int AW     = $clog2(DEPTH);
   localparam int LEN_W  = $clog2(DEPTH + 1);
   localparam int CW     = (LEN_W > LOOP_LEN_W) ? LEN_W : LOOP_LEN_W;
   localparam int DMAX_W = LEN_W + FRAC_BITS;
   localparam int KW     = (DMAX_W > DELAY_W) ? DMAX_W : DELAY_W;
   localparam int FW     = (FRAC_BITS > 0) ? FRAC_BITS : 1;
   localparam int ACC_W  = SAMPLE_W + FW + 3;
   localparam int RND    = (1 << FRAC_BITS) >> 1;

   // store
   logic signed [SAMPLE_W-1:0] store_mem [DEPTH];
   logic signed [SAMPLE_W-1:0] rdata_ff;
   logic        [AW-1:0]       raddr;
   logic        [AW-1:0]       waddr;
   logic signed [SAMPLE_W-1:0] wdata;
   logic                       we;

   // control state
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] write_pos_ff;
   logic [AW-1:0] write_pos_in;
   logic          rsp_valid_ff;

   // transaction registers
   logic signed [SAMPLE_W-1:0]   sample_ff;
   logic        [DELAY_W-1:0]    delay_ff;
   logic signed [SAMPLE_W-1:0]   gain_ff;
   logic                         mute_item_ff;
   logic        [LEN_W-1:0]      len_ff;
   logic        [LEN_W-1:0]      len_in;
   logic        [AW-1:0]         wp_cur_ff;
   logic        [AW-1:0]         wp_cur_in;
   logic        [LEN_W-1:0]      dint_ff;
   logic        [LEN_W-1:0]      dint_in;
   logic        [FW-1:0]         frac_ff;
   logic        [FW-1:0]         frac_in;
   logic        [AW-1:0]         p1_ff;
   logic        [AW-1:0]         p1_in;
   logic        [AW-1:0]         p2_ff;
   logic        [AW-1:0]         p2_in;
   logic signed [ACC_W-1:0]      acc_ff;
   logic signed [ACC_W-1:0]      acc_in;
   logic signed [SAMPLE_W-1:0]   tap_ff;
   logic signed [SAMPLE_W-1:0]   tap_mix_in;
   logic signed [2*SAMPLE_W-1:0] prod_ff;
   logic signed [2*SAMPLE_W-1:0] prod_in;
   logic signed [SAMPLE_W-1:0]   rsp_sample_ff;

   // effective length from loop_length
   logic [CW-1:0] ll_ext;
   assign ll_ext = CW'(cfg.loop_length);

   always_comb begin
      priority if (ll_ext < CW'(2)) begin
         len_in = LEN_W'(2);
      end else if (ll_ext > CW'(DEPTH)) begin
         len_in = LEN_W'(DEPTH);
      end else begin
         len_in = LEN_W'(ll_ext);
      end
   end

   // a position left past a shrunk length reads as zero
   assign wp_cur_in = (LEN_W'(write_pos_ff) >= len_in) ? '0 : write_pos_ff;

   // delay clamp to [1, len-1] whole samples
   logic [KW-1:0] dly_ext;
   logic [KW-1:0] dmin;
   logic [KW-1:0] dmax;
   logic [KW-1:0] dly_c;

   assign dly_ext = KW'(delay_ff);
   assign dmin    = KW'(1) << FRAC_BITS;
   assign dmax    = KW'(len_ff - LEN_W'(1)) << FRAC_BITS;

   always_comb begin
      priority if (dly_ext < dmin) begin
         dly_c = dmin;
      end else if (dly_ext > dmax) begin
         dly_c = dmax;
      end else begin
         dly_c = dly_ext;
      end
   end

   assign dint_in = LEN_W'(dly_c >> FRAC_BITS);
   assign frac_in = (FRAC_BITS > 0) ? FW'(dly_c) : '0;

   // tap addresses, circular over len
   logic [LEN_W:0] wpx;
   logic [LEN_W:0] dx;
   logic [LEN_W:0] lx;
   logic [LEN_W:0] p1_full;

   assign wpx     = (LEN_W + 1)'(wp_cur_ff);
   assign dx      = (LEN_W + 1)'(dint_ff);
   assign lx      = (LEN_W + 1)'(len_ff);
   assign p1_full = (wpx >= dx) ? (wpx - dx) : (wpx + lx - dx);
   assign p1_in   = AW'(p1_full);
   assign p2_in   = (p1_in == '0) ? AW'(len_ff - LEN_W'(1)) : (p1_in - AW'(1));

   // interpolation, first half with x1 and rounding
   logic [FW:0]             w1;
   logic signed [ACC_W-1:0] prod_a;
   logic signed [ACC_W-1:0] prod_b;
   logic signed [ACC_W-1:0] sum_b;
   logic signed [ACC_W-1:0] shifted;

   assign w1     = (FW + 1)'(1 << FRAC_BITS) - {1'b0, frac_ff};
   assign prod_a = ACC_W'(rdata_ff) * ACC_W'($signed({1'b0, w1}));
   assign acc_in = prod_a + $signed(ACC_W'(RND));

   // second half with x2, floor shift
   assign prod_b  = ACC_W'(rdata_ff) * ACC_W'($signed({1'b0, frac_ff}));
   assign sum_b   = acc_ff + prod_b;
   assign shifted = sum_b >>> FRAC_BITS;

   always_comb begin
      priority if (shifted > $signed(ACC_W'(SAMPLE_MAX))) begin
         tap_mix_in = SAMPLE_W'(SAMPLE_MAX);
      end else if (shifted < $signed(ACC_W'(SAMPLE_MIN))) begin
         tap_mix_in = SAMPLE_W'(SAMPLE_MIN);
      end else begin
         tap_mix_in = SAMPLE_W'(shifted);
      end
   end

   // feedback gain, optionally clamped to +-0.99
   logic signed [SAMPLE_W-1:0] g_eff;

   always_comb begin
      g_eff = gain_ff;
      if (cfg.gain_limit) begin
         priority if (gain_ff > PROTECT_POS) begin
            g_eff = PROTECT_POS;
         end else if (gain_ff < PROTECT_NEG) begin
            g_eff = PROTECT_NEG;
         end else begin
            g_eff = gain_ff;
         end
      end
   end

   assign prod_in = (2*SAMPLE_W)'(tap_ff) * (2*SAMPLE_W)'(g_eff);

   // rounded q15 feedback plus input, saturated
   logic signed [SAMPLE_W:0]   fb_val;
   logic signed [SAMPLE_W+1:0] fb_sum;
   logic signed [SAMPLE_W-1:0] fb_sat;

   assign fb_val = (SAMPLE_W + 1)'((prod_ff + 32'sd16384) >>> 15);
   assign fb_sum = (SAMPLE_W + 2)'(sample_ff) + (SAMPLE_W + 2)'(fb_val);

   always_comb begin
      priority if (fb_sum > $signed((SAMPLE_W + 2)'(SAMPLE_MAX))) begin
         fb_sat = SAMPLE_W'(SAMPLE_MAX);
      end else if (fb_sum < $signed((SAMPLE_W + 2)'(SAMPLE_MIN))) begin
         fb_sat = SAMPLE_W'(SAMPLE_MIN);
      end else begin
         fb_sat = SAMPLE_W'(fb_sum);
      end
   end

   // next write position wraps at len
   assign write_pos_in = ((LEN_W'(wp_cur_ff) + LEN_W'(1)) >= len_ff) ? '0
                         : (wp_cur_ff + AW'(1));

   // store ports
   assign raddr = cmd.rd2 ? p2_ff : p1_ff;
   assign we    = cmd.clear || (cmd.done && !mute_item_ff && !cfg.hold);
   assign waddr = cmd.clear ? clr_addr_ff : wp_cur_ff;
   assign wdata = cmd.clear ? '0 : fb_sat;

   always_ff @(posedge clock) begin
      if (we) store_mem[waddr] <= wdata;
      rdata_ff <= store_mem[raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         write_pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) clr_addr_ff <= clr_addr_ff + AW'(1);
         if (cmd.done && !mute_item_ff) write_pos_ff <= write_pos_in;
         if (cmd.done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // transaction payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff    <= req_in_sample;
         delay_ff     <= req_delay_amount;
         gain_ff      <= req_gain;
         mute_item_ff <= cfg.mute;
         len_ff       <= len_in;
         wp_cur_ff    <= wp_cur_in;
      end
      if (cmd.clamp) begin
         dint_ff <= dint_in;
         frac_ff <= frac_in;
      end
      if (cmd.addr) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
      if (cmd.rd2) acc_ff <= acc_in;
      if (cmd.accept) begin
         tap_ff <= '0;
      end else if (cmd.rd2) begin
         tap_ff <= rdata_ff;
      end else if (cmd.mix) begin
         tap_ff <= tap_mix_in;
      end
      if (cmd.fb) prod_ff <= prod_in;
      if (cmd.done) rsp_sample_ff <= tap_ff;
   end

   assign sts.clear_last = (clr_addr_ff == AW'(DEPTH - 1));
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = rsp_sample_ff;

   // clamped delay stays inside the loop
   assert property (@(posedge clock) disable iff (reset)
      cmd.addr |-> (dint_ff >= LEN_W'(1)) && (dint_ff < len_ff))
      else $error("clamped delay outside loop");

   // both taps address live entries
   assert property (@(posedge clock) disable iff (reset)
      cmd.rd1 |-> (LEN_W'(p1_ff) < len_ff) && (LEN_W'(p2_ff) < len_ff))
      else $error("tap address past loop length");

   // position wraps inside the loop after an advance
   assert property (@(posedge clock) disable iff (reset)
      (cmd.done && !mute_item_ff) |=> (LEN_W'(write_pos_ff) < len_ff))
      else $error("write position past loop length");

   // no accept, no transaction store write and no result during the clearing sweep
   assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !cmd.done && !cmd.accept)
      else $error("transaction during clearing sweep");

endmodule

// File: rtl/core/fractional_feedback_delay_line_top.sv
// top level of the fractional feedback delay line
// depends on ffdl_pkg, ffdl_req_if, ffdl_rsp_if, ffdl_csr, ffdl_ctrl, ffdl_datapath

// Single-channel circular delay line with feedback. Each req transaction carries a
// q1.15 sample, a delay in samples with FRAC_BITS fraction bits and a q1.15 feedback
// gain; each gives exactly one rsp transaction holding the tap read behind the write
// position, or zero in mute. Transactions are processed one at a time by a sequencer:
// accept, clamp, address, first tap read, second tap read, blend (interpolation on
// only), feedback and done, or accept and done in mute; done waits for rsp ready
// while the result register is full. The steps follow from the store's single
// registered read port (the two taps are read in successive cycles) and the multiply
// steps of the blend and the feedback, each in a state of its own. After reset a
// clearing pass writes zero to every store entry, one per cycle, DEPTH entries (4096
// by default); req ready stays low during the pass, csr writes are taken throughout.
// Configuration is expected to change only between transactions.

module fractional_feedback_delay_line_top
   import ffdl_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   ffdl_req_if.sink              req_ch,
   ffdl_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   ffdl_cfg_type               cfg;
   ffdl_cmd_type               cmd;
   ffdl_sts_type               sts;
   logic                       ready;
   logic                       rsp_valid;
   logic signed [SAMPLE_W-1:0] rsp_sample;

   // register file
   ffdl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer: clearing sweep, accept, clamp, address, two reads, blend, feedback, done
   ffdl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_ch.valid),
      .req_ready (ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // store, arithmetic and the result register that decouples rsp from req
   ffdl_datapath #(
      .DEPTH     (DEPTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .sts              (sts),
      .req_in_sample    (req_ch.in_sample),
      .req_delay_amount (req_ch.delay_amount),
      .req_gain         (req_ch.gain),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_out_sample   (rsp_sample)
   );

   // channel hookup
   assign req_ch.ready      = ready;
   assign rsp_ch.valid      = rsp_valid;
   assign rsp_ch.out_sample = rsp_sample;

endmodule
